// ===== sv/slpl_pkg.sv =====
package slpl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int THR_W    = 23;
  localparam int COEF_W   = 24;
  localparam int HOLD_W   = 11;
  localparam int ENV_W    = 32;
  localparam int QUO_W    = 16;
  localparam int GAIN_W   = 17;
  localparam int PROD_W   = ENV_W + COEF_W;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [THR_W-1:0]  THR_MIN  = 23'd105;
  localparam logic [THR_W-1:0]  THR_RST  = 23'd1048576;
  localparam logic [COEF_W-1:0] ATK_RST  = 24'd16602910;
  localparam logic [COEF_W-1:0] REL_RST  = 24'd16759703;
  localparam logic [HOLD_W-1:0] HOLD_RST = 11'd441;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
  localparam logic [THR_W-1:0]  MAG_MAX  = 23'h7FFFFF;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2,
    REG_HOLD      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_t;

  typedef struct packed {
    logic [THR_W-1:0]           link;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [COEF_W-1:0] atk;
    logic [COEF_W-1:0] rel;
    logic [HOLD_W-1:0] hold;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PEAK,
    B_ENV_MUL,
    B_ENV_UPD,
    B_MOD,
    B_DIV,
    B_MEM,
    B_MUL,
    B_OUT
  } back_state_t;

  function automatic logic [THR_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] m;
    m = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
    return m[SAMPLE_W-1] ? MAG_MAX : m[THR_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] apply_gain(input logic [SAMPLE_W-1:0] s,
                                                      input logic [GAIN_W-1:0] gain);
    logic [SAMPLE_W-1:0]        m;
    logic [SAMPLE_W+GAIN_W-1:0] p;
    logic [SAMPLE_W-1:0]        r;
    m = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
    p = (SAMPLE_W+GAIN_W)'(m) * (SAMPLE_W+GAIN_W)'(gain);
    r = p[SAMPLE_W+QUO_W-1:QUO_W];
    return s[SAMPLE_W-1] ? (~r + 1'b1) : r;
  endfunction

endpackage

// ===== sv/slpl_front.sv =====
module slpl_front (
  input  slpl_pkg::in_t          in_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [slpl_pkg::THR_W-1:0] thr,
  input  logic                   q_full,
  output logic                   q_push,
  output slpl_pkg::item_t        q_item
);

  logic [slpl_pkg::THR_W-1:0] mag_l;
  logic [slpl_pkg::THR_W-1:0] mag_r;
  logic [slpl_pkg::THR_W-1:0] mag_max;

  always_comb begin
    mag_l   = slpl_pkg::magnitude(in_data.left_in);
    mag_r   = slpl_pkg::magnitude(in_data.right_in);
    mag_max = (mag_r > mag_l) ? mag_r : mag_l;
    q_item.link  = (mag_max < thr) ? thr : mag_max;
    q_item.left  = in_data.left_in;
    q_item.right = in_data.right_in;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== sv/slpl_queue.sv =====
module slpl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  slpl_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output slpl_pkg::item_t pop_item
);

  slpl_pkg::item_t mem_r [2];
  logic            wr_ptr_r;
  logic            wr_ptr_nxt;
  logic            rd_ptr_r;
  logic            rd_ptr_nxt;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/slpl_back.sv =====
module slpl_back #(
  parameter int DELAY_DEPTH = 2048
) (
  input  logic            clk,
  input  logic            rst_n,
  input  slpl_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  slpl_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output slpl_pkg::out_t  out_data
);

  localparam int AW = (DELAY_DEPTH > 2) ? $clog2(DELAY_DEPTH) : 1;
  localparam int HW = slpl_pkg::HOLD_W;
  localparam int RW = ((AW > HW) ? AW : HW) + 1;
  localparam int EW = slpl_pkg::ENV_W;
  localparam int SW = slpl_pkg::SAMPLE_W;

  slpl_pkg::back_state_t state_r, state_nxt;

  slpl_pkg::item_t            item_r, item_nxt;
  logic [slpl_pkg::THR_W-1:0] held_r, held_nxt;
  logic [HW-1:0]              hcnt_r, hcnt_nxt;
  logic [EW-1:0]              env_r, env_nxt;
  logic [slpl_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                       rising_r, rising_nxt;
  logic [HW-1:0]              acc_r, acc_nxt;
  logic [AW-1:0]              rd_r, rd_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic                       full_r, full_nxt;
  logic                       gone_r, gone_nxt;
  logic [EW-1:0]              rem_r, rem_nxt;
  logic [slpl_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [3:0]                 dcnt_r, dcnt_nxt;
  logic                       rvalid_r, rvalid_nxt;
  slpl_pkg::out_t             res_r, res_nxt;
  slpl_pkg::out_t             odata_r, odata_nxt;
  logic                       ovalid_r, ovalid_nxt;

  logic [2*SW-1:0] mem [DELAY_DEPTH];
  logic [2*SW-1:0] rdata_r;
  logic            mem_we;

  logic [EW-1:0]   target;
  logic [EW-1:0]   diff;
  logic [EW-1:0]   step;
  logic [EW-1:0]   thr_sh;
  logic [HW-1:0]   hcnt0;
  logic            reload;
  logic [RW-1:0]   wp_ext;
  logic [RW-1:0]   acc_ext;
  logic [RW-1:0]   rd_calc;
  logic [EW:0]     rem2;
  logic [slpl_pkg::GAIN_W-1:0] gain;
  logic [SW-1:0]   ls;
  logic [SW-1:0]   rs;

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    held_nxt   = held_r;
    hcnt_nxt   = hcnt_r;
    env_nxt    = env_r;
    prod_nxt   = prod_r;
    rising_nxt = rising_r;
    acc_nxt    = acc_r;
    rd_nxt     = rd_r;
    wp_nxt     = wp_r;
    full_nxt   = full_r;
    gone_nxt   = gone_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    rvalid_nxt = rvalid_r;
    res_nxt    = res_r;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r && !out_ready;
    q_pop      = 1'b0;
    mem_we     = 1'b0;

    target  = {1'b0, held_r, 8'b0};
    diff    = (target > env_r) ? (target - env_r) : (env_r - target);
    step    = prod_r[slpl_pkg::PROD_W-1:slpl_pkg::COEF_W];
    thr_sh  = {1'b0, cfg.thr, 8'b0};
    reload  = (hcnt_r >= cfg.hold) || (item_r.link > held_r);
    hcnt0   = reload ? '0 : hcnt_r;
    wp_ext  = RW'(wp_r);
    acc_ext = RW'(acc_r);
    rd_calc = (wp_ext >= acc_ext) ? (wp_ext - acc_ext)
                                  : (wp_ext + RW'(DELAY_DEPTH) - acc_ext);
    rem2    = {rem_r, 1'b0};
    gain    = gone_r ? slpl_pkg::GAIN_ONE : {1'b0, quo_r};
    ls      = rvalid_r ? rdata_r[2*SW-1:SW] : '0;
    rs      = rvalid_r ? rdata_r[SW-1:0] : '0;

    case (state_r)
      slpl_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          state_nxt = slpl_pkg::B_PEAK;
        end
      end
      slpl_pkg::B_PEAK: begin
        if (reload) begin
          held_nxt = item_r.link;
        end
        hcnt_nxt  = (hcnt0 < cfg.hold) ? hcnt0 + 1'b1 : hcnt0;
        acc_nxt   = cfg.hold;
        state_nxt = slpl_pkg::B_ENV_MUL;
      end
      slpl_pkg::B_ENV_MUL: begin
        rising_nxt = target > env_r;
        prod_nxt   = slpl_pkg::PROD_W'(diff) *
                     slpl_pkg::PROD_W'(rising_nxt ? cfg.atk : cfg.rel);
        state_nxt  = slpl_pkg::B_ENV_UPD;
      end
      slpl_pkg::B_ENV_UPD: begin
        env_nxt   = rising_r ? (target - step) : (target + step);
        state_nxt = slpl_pkg::B_MOD;
      end
      slpl_pkg::B_MOD: begin
        if (32'(acc_r) >= 32'(DELAY_DEPTH)) begin
          acc_nxt = acc_r - HW'(DELAY_DEPTH);
        end else begin
          rd_nxt    = AW'(rd_calc);
          gone_nxt  = env_r <= thr_sh;
          rem_nxt   = thr_sh;
          quo_nxt   = '0;
          dcnt_nxt  = 4'd15;
          state_nxt = slpl_pkg::B_DIV;
        end
      end
      slpl_pkg::B_DIV: begin
        if (gone_r) begin
          state_nxt = slpl_pkg::B_MEM;
        end else begin
          if (rem2 >= {1'b0, env_r}) begin
            rem_nxt = EW'(rem2 - {1'b0, env_r});
            quo_nxt = {quo_r[slpl_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem2[EW-1:0];
            quo_nxt = {quo_r[slpl_pkg::QUO_W-2:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 1'b1;
          if (dcnt_r == 4'd0) begin
            state_nxt = slpl_pkg::B_MEM;
          end
        end
      end
      slpl_pkg::B_MEM: begin
        mem_we     = 1'b1;
        rvalid_nxt = full_r || (rd_r < wp_r);
        if (wp_r == AW'(DELAY_DEPTH - 1)) begin
          wp_nxt   = '0;
          full_nxt = 1'b1;
        end else begin
          wp_nxt = wp_r + 1'b1;
        end
        state_nxt = slpl_pkg::B_MUL;
      end
      slpl_pkg::B_MUL: begin
        res_nxt.left_out  = slpl_pkg::apply_gain(ls, gain);
        res_nxt.right_out = slpl_pkg::apply_gain(rs, gain);
        state_nxt = slpl_pkg::B_OUT;
      end
      slpl_pkg::B_OUT: begin
        if (!ovalid_r || out_ready) begin
          odata_nxt  = res_r;
          ovalid_nxt = 1'b1;
          state_nxt  = slpl_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = slpl_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= slpl_pkg::B_IDLE;
      held_r   <= slpl_pkg::THR_RST;
      hcnt_r   <= '0;
      env_r    <= {1'b0, slpl_pkg::THR_RST, 8'b0};
      wp_r     <= '0;
      full_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      hcnt_r   <= hcnt_nxt;
      env_r    <= env_nxt;
      wp_r     <= wp_nxt;
      full_r   <= full_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    prod_r   <= prod_nxt;
    rising_r <= rising_nxt;
    acc_r    <= acc_nxt;
    rd_r     <= rd_nxt;
    gone_r   <= gone_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dcnt_r   <= dcnt_nxt;
    rvalid_r <= rvalid_nxt;
    res_r    <= res_nxt;
    odata_r  <= odata_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rdata_r  <= mem[rd_r];
      mem[wp_r] <= {item_r.left, item_r.right};
    end
  end

endmodule

// ===== sv/stereo_lookahead_peak_limiter.sv =====
// Stereo look-ahead peak limiter with linked channels.
// in_valid/in_ready/in_data carry one stereo sample pair (Q4.20) per beat;
// out_valid/out_ready/out_data carry the limited pair, one beat per input
// beat, in order. The output is the pair from hold_length beats earlier
// times a gain of threshold / envelope, at most 1.0.
// An input beat is classified on acceptance and queued (two entries); a
// sequencer then runs peak hold, envelope multiply, a 16-step gain divider,
// the delay line access and the gain multiply.
// The divider is skipped when the gain saturates at 1.0, and the delay
// offset takes one extra reduction step per DELAY_DEPTH that hold_length
// spans beyond it. The sequencer finishes one pair before it takes the
// next from the queue, so the serial gain divider sets the pair rate.
// Registers on the cfg_ APB port: threshold at 0x0, attack coefficient at
// 0x4, release coefficient at 0x8, hold length at 0xC; write only while idle.
// Reset: registers take their defaults, the delay line reads as silence
// until written, and no clearing pass is needed.
// When out_ready is low the finished result waits in the output register;
// the queue keeps accepting until it is full, then in_ready drops.
module stereo_lookahead_peak_limiter #(
  parameter int DELAY_DEPTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  slpl_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output slpl_pkg::out_t                out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [slpl_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [slpl_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [slpl_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [slpl_pkg::THR_W-1:0]  thr_r;
  logic [slpl_pkg::COEF_W-1:0] atk_r;
  logic [slpl_pkg::COEF_W-1:0] rel_r;
  logic [slpl_pkg::HOLD_W-1:0] hold_r;
  slpl_pkg::reg_idx_t          idx;
  logic                        wr_en;
  slpl_pkg::cfg_t              cfg;

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  slpl_pkg::item_t push_item;
  slpl_pkg::item_t pop_item;

  assign cfg_pready = 1'b1;
  assign idx        = slpl_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg.thr  = (thr_r < slpl_pkg::THR_MIN) ? slpl_pkg::THR_MIN : thr_r;
    cfg.atk  = atk_r;
    cfg.rel  = rel_r;
    cfg.hold = (hold_r == '0) ? slpl_pkg::HOLD_W'(1) : hold_r;
  end

  always_comb begin
    case (idx)
      slpl_pkg::REG_THRESHOLD: cfg_prdata = slpl_pkg::APB_DW'(thr_r);
      slpl_pkg::REG_ATTACK:    cfg_prdata = slpl_pkg::APB_DW'(atk_r);
      slpl_pkg::REG_RELEASE:   cfg_prdata = slpl_pkg::APB_DW'(rel_r);
      slpl_pkg::REG_HOLD:      cfg_prdata = slpl_pkg::APB_DW'(hold_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= slpl_pkg::THR_RST;
      atk_r  <= slpl_pkg::ATK_RST;
      rel_r  <= slpl_pkg::REL_RST;
      hold_r <= slpl_pkg::HOLD_RST;
    end else if (wr_en) begin
      case (idx)
        slpl_pkg::REG_THRESHOLD: thr_r  <= cfg_pwdata[slpl_pkg::THR_W-1:0];
        slpl_pkg::REG_ATTACK:    atk_r  <= cfg_pwdata[slpl_pkg::COEF_W-1:0];
        slpl_pkg::REG_RELEASE:   rel_r  <= cfg_pwdata[slpl_pkg::COEF_W-1:0];
        slpl_pkg::REG_HOLD:      hold_r <= cfg_pwdata[slpl_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  slpl_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .thr      (cfg.thr),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  slpl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  slpl_back #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/slpl_checker.sv =====
module slpl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input slpl_pkg::out_t out_data,
  input logic           cfg_pready
);

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

endmodule

bind stereo_lookahead_peak_limiter slpl_checker u_slpl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
